// ----- hdl/smmr_pkg.sv -----
// Package for the streaming minimum, maximum and RMS block.
// Holds the per-run statistics record, the back-end state codes and queue sizing.
// No dependencies.
`default_nettype none

package smmr_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int INDEX_W     = 10;
   localparam int ROOT_W      = 16;
   localparam int QUOT_W      = 32;
   localparam int ROOT_REM_W  = 18;
   localparam int SQUARE_W    = 31;
   localparam int QUEUE_DEPTH = 2;
   localparam int FILL_W      = 2;

   // Statistics of one finished run, apart from the sum and the count.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] min_value;
      logic signed [SAMPLE_W-1:0] max_value;
      logic        [INDEX_W-1:0]  min_index;
      logic        [INDEX_W-1:0]  max_index;
   } stats_type;

   localparam int STATS_W = $bits(stats_type);

   // Back-end sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_ROOT = 4'b0100,
      ST_DONE = 4'b1000
   } back_state_type;

endpackage

`default_nettype wire

// ----- hdl/smmr_front.sv -----
// Front end: accepts samples, tracks running minimum and maximum with positions,
// squares each sample and accumulates the sum of squares. Uses smmr_pkg.
`default_nettype none

module smmr_front #(
   parameter int MAX_RUN = 1024,
   parameter int CNT_W   = 11,
   parameter int SUM_W   = 41
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  accept,
   input  wire logic signed [smmr_pkg::SAMPLE_W-1:0] sample,
   input  wire                                  last,
   output logic                                 push,
   output smmr_pkg::stats_type                  push_stats,
   output logic [CNT_W-1:0]                     push_count,
   output logic [SUM_W-1:0]                     push_sum,
   output logic                                 pending
);

   logic [CNT_W-1:0]                      count_ff, count_in;
   logic signed [smmr_pkg::SAMPLE_W-1:0]  min_ff, min_in, max_ff, max_in;
   logic [smmr_pkg::INDEX_W-1:0]          min_pos_ff, min_pos_in, max_pos_ff, max_pos_in;
   logic [SUM_W-1:0]                      sum_ff, sum_in;
   logic                                  valid_ff, counted_ff, last_ff;
   logic [smmr_pkg::SQUARE_W-1:0]         square_ff;
   smmr_pkg::stats_type                   snap_stats_ff;
   logic [CNT_W-1:0]                      snap_count_ff;

   logic                                  counted;
   logic [CNT_W-1:0]                      count_inc;
   logic [smmr_pkg::INDEX_W-1:0]          pos;
   logic [CNT_W+smmr_pkg::INDEX_W-1:0]    pos_wide;
   logic signed [2*smmr_pkg::SAMPLE_W-1:0] product;
   logic [SUM_W-1:0]                      sum_added;

   always_comb begin
      counted   = count_ff < CNT_W'(MAX_RUN);
      count_inc = count_ff + CNT_W'(1);
      pos_wide  = {{smmr_pkg::INDEX_W{1'b0}}, count_ff};
      pos       = pos_wide[smmr_pkg::INDEX_W-1:0];
      product   = sample * sample;

      min_in     = min_ff;
      max_in     = max_ff;
      min_pos_in = min_pos_ff;
      max_pos_in = max_pos_ff;
      count_in   = count_ff;
      if (accept && counted) begin
         if (count_ff == '0) begin
            min_in     = sample;
            max_in     = sample;
            min_pos_in = '0;
            max_pos_in = '0;
         end else if (sample > max_ff) begin
            max_in     = sample;
            max_pos_in = pos;
         end else if (sample < min_ff) begin
            min_in     = sample;
            min_pos_in = pos;
         end
         count_in = count_inc;
      end
      if (accept && last) begin
         count_in = '0;
      end

      // Second stage: add the registered square into the running sum.
      sum_added = counted_ff ? sum_ff + SUM_W'(square_ff) : sum_ff;
      sum_in    = sum_ff;
      if (valid_ff) begin
         sum_in = last_ff ? '0 : sum_added;
      end

      push       = valid_ff && last_ff;
      push_stats = snap_stats_ff;
      push_count = snap_count_ff;
      push_sum   = sum_added;
      pending    = push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         min_ff     <= '0;
         max_ff     <= '0;
         min_pos_ff <= '0;
         max_pos_ff <= '0;
         sum_ff     <= '0;
         valid_ff   <= 1'b0;
      end else begin
         count_ff   <= count_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         min_pos_ff <= min_pos_in;
         max_pos_ff <= max_pos_in;
         sum_ff     <= sum_in;
         valid_ff   <= accept;
      end
   end

   always_ff @(posedge clock) begin
      counted_ff <= counted;
      last_ff    <= last;
      square_ff  <= product[smmr_pkg::SQUARE_W-1:0];
      if (accept && last) begin
         snap_stats_ff.min_value <= min_in;
         snap_stats_ff.max_value <= max_in;
         snap_stats_ff.min_index <= min_pos_in;
         snap_stats_ff.max_index <= max_pos_in;
         snap_count_ff           <= counted ? count_inc : count_ff;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/smmr_queue.sv -----
// Short register queue of finished run records between front and back end.
// Uses smmr_pkg for its depth and fill-count width.
`default_nettype none

module smmr_queue #(
   parameter int WIDTH = 116
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire [WIDTH-1:0]  push_data,
   input  wire              pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full,
   output logic             almost_full
);

   logic [WIDTH-1:0]              entry_ff [smmr_pkg::QUEUE_DEPTH];
   logic [smmr_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic                          wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;

   always_comb begin
      empty       = fill_ff == '0;
      full        = fill_ff == smmr_pkg::FILL_W'(smmr_pkg::QUEUE_DEPTH);
      almost_full = fill_ff >= smmr_pkg::FILL_W'(smmr_pkg::QUEUE_DEPTH - 1);
      pop_data    = entry_ff[rd_ptr_ff];
      wr_ptr_in   = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in   = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in     = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + smmr_pkg::FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - smmr_pkg::FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/smmr_back.sv -----
// Back end: takes one run record, divides the sum of squares by the count one
// bit per cycle, takes the integer square root two bits per cycle, and holds
// the result in an output register. Uses smmr_pkg.
`default_nettype none

module smmr_back #(
   parameter int CNT_W = 11,
   parameter int SUM_W = 41
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   rec_valid,
   input  wire smmr_pkg::stats_type              rec_stats,
   input  wire [CNT_W-1:0]                       rec_count,
   input  wire [SUM_W-1:0]                       rec_sum,
   output logic                                  rec_pop,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic signed [smmr_pkg::SAMPLE_W-1:0]  rsp_min_value,
   output logic signed [smmr_pkg::SAMPLE_W-1:0]  rsp_max_value,
   output logic [smmr_pkg::INDEX_W-1:0]          rsp_min_index,
   output logic [smmr_pkg::INDEX_W-1:0]          rsp_max_index,
   output logic [smmr_pkg::ROOT_W-1:0]           rsp_rms_value
);

   localparam int STEP_W = $clog2(SUM_W);

   smmr_pkg::back_state_type          state_ff, state_in;
   smmr_pkg::stats_type               stats_ff;
   logic [CNT_W-1:0]                  divisor_ff;
   logic [SUM_W-1:0]                  dividend_ff, dividend_in;
   logic [CNT_W-1:0]                  rem_ff, rem_in;
   logic [STEP_W-1:0]                 step_ff, step_in;
   logic [smmr_pkg::QUOT_W-1:0]       val_ff, val_in;
   logic [smmr_pkg::ROOT_REM_W-1:0]   srem_ff, srem_in;
   logic [smmr_pkg::ROOT_W-1:0]       root_ff, root_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   smmr_pkg::stats_type               out_stats_ff;
   logic [smmr_pkg::ROOT_W-1:0]       out_rms_ff;

   logic [CNT_W:0]                    rem_shift, rem_diff;
   logic                              qbit;
   logic [SUM_W-1:0]                  dividend_next;
   logic [SUM_W+smmr_pkg::QUOT_W-1:0] quot_wide;
   logic [smmr_pkg::ROOT_REM_W-1:0]   srem_shift, trial;
   logic                              load_out;

   always_comb begin
      // Restoring division step.
      rem_shift     = {rem_ff, dividend_ff[SUM_W-1]};
      rem_diff      = rem_shift - {1'b0, divisor_ff};
      qbit          = rem_shift >= {1'b0, divisor_ff};
      dividend_next = {dividend_ff[SUM_W-2:0], qbit};
      quot_wide     = {{smmr_pkg::QUOT_W{1'b0}}, dividend_next};

      // Digit-by-digit square root step.
      srem_shift = {srem_ff[smmr_pkg::ROOT_REM_W-3:0],
                    val_ff[smmr_pkg::QUOT_W-1 -: 2]};
      trial      = {root_ff, 2'b01};

      state_in     = state_ff;
      dividend_in  = dividend_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      val_in       = val_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      rec_pop      = 1'b0;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         smmr_pkg::ST_IDLE: begin
            if (rec_valid) begin
               rec_pop     = 1'b1;
               dividend_in = rec_sum;
               rem_in      = '0;
               step_in     = STEP_W'(SUM_W - 1);
               state_in    = smmr_pkg::ST_DIV;
            end
         end
         smmr_pkg::ST_DIV: begin
            dividend_in = dividend_next;
            rem_in      = qbit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            step_in     = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               val_in   = quot_wide[smmr_pkg::QUOT_W-1:0];
               srem_in  = '0;
               root_in  = '0;
               step_in  = STEP_W'(smmr_pkg::ROOT_W - 1);
               state_in = smmr_pkg::ST_ROOT;
            end
         end
         smmr_pkg::ST_ROOT: begin
            val_in  = {val_ff[smmr_pkg::QUOT_W-3:0], 2'b00};
            step_in = step_ff - STEP_W'(1);
            if (srem_shift >= trial) begin
               srem_in = srem_shift - trial;
               root_in = {root_ff[smmr_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = srem_shift;
               root_in = {root_ff[smmr_pkg::ROOT_W-2:0], 1'b0};
            end
            if (step_ff == '0) begin
               state_in = smmr_pkg::ST_DONE;
            end
         end
         smmr_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = smmr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smmr_pkg::ST_IDLE;
         end
      endcase

      rsp_valid     = rsp_valid_ff;
      rsp_min_value = out_stats_ff.min_value;
      rsp_max_value = out_stats_ff.max_value;
      rsp_min_index = out_stats_ff.min_index;
      rsp_max_index = out_stats_ff.max_index;
      rsp_rms_value = out_rms_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smmr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      val_ff      <= val_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      if (rec_pop) begin
         stats_ff   <= rec_stats;
         divisor_ff <= rec_count;
      end
      if (load_out) begin
         out_stats_ff <= stats_ff;
         out_rms_ff   <= root_ff;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/stream_min_max_rms.sv -----
// Top level of the streaming minimum, maximum and RMS block.
// Instantiates smmr_front, smmr_queue and smmr_back; uses smmr_pkg.
//
// Usage. Samples arrive on the req_ channel, one transfer per sample, with
// req_last marking the final sample of a run. Each run yields exactly one
// transfer on the rsp_ channel: the minimum and maximum, the positions at which
// each was first set, and the floor integer square root of the floor mean of
// the squared samples. Samples past MAX_RUN in one run are ignored, though a
// last flag on such a sample still closes the run.
// Throughput: the front end takes one sample every cycle while req_ready is
// high. Each finished run is handed through a two-entry queue to the back end,
// whose shared divider and root unit work on one run at a time. Runs shorter
// than the back end's time on one run fill the queue, and req_ready then drops
// until the back end frees an entry. The last sample of a run passes through
// the front end's registers and the queue, then the back end's division, root
// and done states, before rsp_valid rises.
// Reset clears all running state and empties the queue; no result is pending
// afterwards. When the receiver stalls, the result waits in the output
// register, the back end holds its next result, and the front end keeps
// accepting samples until the queue is full.
`default_nettype none

module stream_min_max_rms #(
   parameter int MAX_RUN = 1024
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire logic signed [smmr_pkg::SAMPLE_W-1:0] req_sample,
   input  wire                                  req_last,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic signed [smmr_pkg::SAMPLE_W-1:0] rsp_min_value,
   output logic signed [smmr_pkg::SAMPLE_W-1:0] rsp_max_value,
   output logic [smmr_pkg::INDEX_W-1:0]         rsp_min_index,
   output logic [smmr_pkg::INDEX_W-1:0]         rsp_max_index,
   output logic [smmr_pkg::ROOT_W-1:0]          rsp_rms_value
);

   // The count must hold MAX_RUN itself; the sum holds MAX_RUN squares of 2**30.
   localparam int CNT_W   = $clog2(MAX_RUN + 1);
   localparam int SUM_W   = smmr_pkg::SQUARE_W - 1 + CNT_W;
   localparam int ENTRY_W = smmr_pkg::STATS_W + CNT_W + SUM_W;

   logic                 accept;
   logic                 push, pending, pop;
   smmr_pkg::stats_type  push_stats, pop_stats;
   logic [CNT_W-1:0]     push_count, pop_count;
   logic [SUM_W-1:0]     push_sum, pop_sum;
   logic [ENTRY_W-1:0]   push_data, pop_data;
   logic                 empty, full, almost_full;

   // A run closed in the front end is pushed into the queue in the cycle after its
   // last transfer, so its entry is reserved before another sample is taken.
   always_comb begin
      req_ready = !full && !(almost_full && pending);
      accept    = req_valid && req_ready;
      push_data = {push_stats, push_count, push_sum};
      {pop_stats, pop_count, pop_sum} = pop_data;
   end

   smmr_front #(
      .MAX_RUN (MAX_RUN),
      .CNT_W   (CNT_W),
      .SUM_W   (SUM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .sample     (req_sample),
      .last       (req_last),
      .push       (push),
      .push_stats (push_stats),
      .push_count (push_count),
      .push_sum   (push_sum),
      .pending    (pending)
   );

   smmr_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_data   (push_data),
      .pop         (pop),
      .pop_data    (pop_data),
      .empty       (empty),
      .full        (full),
      .almost_full (almost_full)
   );

   smmr_back #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .rec_valid     (!empty),
      .rec_stats     (pop_stats),
      .rec_count     (pop_count),
      .rec_sum       (pop_sum),
      .rec_pop       (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_min_value (rsp_min_value),
      .rsp_max_value (rsp_max_value),
      .rsp_min_index (rsp_min_index),
      .rsp_max_index (rsp_max_index),
      .rsp_rms_value (rsp_rms_value)
   );

endmodule

`default_nettype wire
